### hw/rtl/tbd_pkg.sv
// Shared types and codes for the turtle bitmap drawer.
package tbd_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_PEN_UP   = 3'd0,
		REQ_PEN_DOWN = 3'd1,
		REQ_RIGHT    = 3'd2,
		REQ_LEFT     = 3'd3,
		REQ_MOVE     = 3'd4,
		REQ_READ     = 3'd5
	} req_t;

	// heading, right turn adds one, left turn subtracts one, modulo four
	typedef enum logic [1:0] {
		HEAD_COL_UP   = 2'd0,
		HEAD_ROW_UP   = 2'd1,
		HEAD_COL_DOWN = 2'd2,
		HEAD_ROW_DOWN = 2'd3
	} heading_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_STEP = 5'b00010,
		ST_RD   = 5'b00100,
		ST_WR   = 5'b01000,
		ST_READ = 5'b10000
	} state_t;

	// width of a row word on the output
	localparam int unsigned OUT_W = 32;

endpackage

### hw/rtl/tbd_ram.sv
// Generic single write, single read RAM with registered read data.
module tbd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/tbd_step_unit.sv
// Shared position unit: next cell along the heading and grid edge check.
module tbd_step_unit #(
	parameter int unsigned GRID_SIZE = 32
) (
	input  tbd_pkg::heading_t            heading,
	input  logic [$clog2(GRID_SIZE)-1:0] row,
	input  logic [$clog2(GRID_SIZE)-1:0] col,
	output logic [$clog2(GRID_SIZE)-1:0] row_nxt,
	output logic [$clog2(GRID_SIZE)-1:0] col_nxt,
	output logic                         at_edge
);

	localparam int unsigned POS_W = $clog2(GRID_SIZE);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(GRID_SIZE - 1);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

	always_comb begin
		row_nxt = row;
		col_nxt = col;
		unique case (heading)
			tbd_pkg::HEAD_COL_UP: begin
				col_nxt = col + POS_ONE;
				at_edge = (col == POS_MAX);
			end
			tbd_pkg::HEAD_ROW_UP: begin
				row_nxt = row + POS_ONE;
				at_edge = (row == POS_MAX);
			end
			tbd_pkg::HEAD_COL_DOWN: begin
				col_nxt = col - POS_ONE;
				at_edge = (col == '0);
			end
			tbd_pkg::HEAD_ROW_DOWN: begin
				row_nxt = row - POS_ONE;
				at_edge = (row == '0);
			end
		endcase
	end

endmodule

### hw/rtl/turtle_bitmap_drawer_core.sv
// Turtle bitmap drawer: pen, turn and move commands on a square bitmap, with row read back.
// Pen and turn words leave busy low, and the next word may follow at once.
// A move holds busy until the clipped distance is walked: each step passes ST_STEP with the pen
// up, and ST_STEP, ST_RD and ST_WR with it down; each marked cell is one read-modify-write of
// its bitmap row. Read back holds busy through ST_READ and while its last address is pending;
// rows come one per cycle via the RAM read and output registers. The receiver cannot stall: one strobe per row.
// Reset clears the pose and pen at once and empties the bitmap through per-row valid bits.
module turtle_bitmap_drawer_core #(
	parameter int unsigned GRID_SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  distance,
	output logic        strobe,
	output logic [4:0]  row_index,
	output logic [31:0] row_bits,
	output logic        last_row
);

	localparam int unsigned POS_W    = $clog2(GRID_SIZE);
	localparam int unsigned OUT_ROWS = (GRID_SIZE < 32) ? GRID_SIZE : 32;
	localparam int unsigned OUT_COLS = (GRID_SIZE < tbd_pkg::OUT_W) ? GRID_SIZE : tbd_pkg::OUT_W;
	localparam int unsigned RD_W     = $clog2(OUT_ROWS);
	localparam logic [RD_W-1:0] RD_LAST = RD_W'(OUT_ROWS - 1);

	// sequencer and turtle pose
	tbd_pkg::state_t   state_q;
	tbd_pkg::heading_t heading_q;
	logic [POS_W-1:0]  row_pos_q;
	logic [POS_W-1:0]  col_pos_q;
	logic              pen_q;
	logic [7:0]        remaining_q;
	logic [RD_W-1:0]   rd_cnt_q;

	// a row whose valid bit is clear reads as all cells cleared
	logic [GRID_SIZE-1:0] row_valid_q;
	logic                 row_vld_q;

	// read back pipeline: address issued, then data captured into the output
	logic            pend_s1;
	logic [RD_W-1:0] pend_idx_s1;
	logic            pend_last_s1;
	logic            pend_vld_s1;

	logic        strobe_q;
	logic [4:0]  row_index_q;
	logic [31:0] row_bits_q;
	logic        last_row_q;

	// shared step unit
	logic [POS_W-1:0] row_nxt;
	logic [POS_W-1:0] col_nxt;
	logic             at_edge;

	// RAM port
	logic                 ram_we;
	logic [POS_W-1:0]     ram_raddr;
	logic [GRID_SIZE-1:0] ram_wdata;
	logic [GRID_SIZE-1:0] ram_rdata;
	logic [GRID_SIZE-1:0] row_old;
	logic [31:0]          out_bits;

	logic accept;

	tbd_step_unit #(
		.GRID_SIZE(GRID_SIZE)
	) u_step (
		.heading(heading_q),
		.row    (row_pos_q),
		.col    (col_pos_q),
		.row_nxt(row_nxt),
		.col_nxt(col_nxt),
		.at_edge(at_edge)
	);

	tbd_ram #(
		.WIDTH(GRID_SIZE),
		.DEPTH(GRID_SIZE)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(row_pos_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy   = (state_q != tbd_pkg::ST_IDLE) || pend_s1;
	assign accept = start && !busy;

	// read address: current row during a mark, row counter during read back
	assign ram_raddr = (state_q == tbd_pkg::ST_READ) ? POS_W'(rd_cnt_q) : row_pos_q;

	// mark: merge the turtle's cell into the row just read
	assign ram_we    = (state_q == tbd_pkg::ST_WR);
	assign row_old   = row_vld_q ? ram_rdata : '0;
	assign ram_wdata = row_old | (GRID_SIZE'(1) << col_pos_q);

	// row word for the output, columns past the word are not shown
	always_comb begin
		out_bits = '0;
		for (int i = 0; i < OUT_COLS; i++) begin
			out_bits[i] = pend_vld_s1 & ram_rdata[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbd_pkg::ST_IDLE;
			heading_q   <= tbd_pkg::HEAD_COL_UP;
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			pen_q       <= 1'b0;
			remaining_q <= '0;
			rd_cnt_q    <= '0;
			row_valid_q <= '0;
			pend_s1     <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			pend_s1  <= 1'b0;
			strobe_q <= pend_s1;
			unique case (state_q)
				tbd_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							tbd_pkg::REQ_PEN_UP:   pen_q <= 1'b0;
							tbd_pkg::REQ_PEN_DOWN: pen_q <= 1'b1;
							tbd_pkg::REQ_RIGHT:
								heading_q <= tbd_pkg::heading_t'(heading_q + 2'd1);
							tbd_pkg::REQ_LEFT:
								heading_q <= tbd_pkg::heading_t'(heading_q - 2'd1);
							tbd_pkg::REQ_MOVE: begin
								remaining_q <= distance;
								state_q     <= tbd_pkg::ST_STEP;
							end
							tbd_pkg::REQ_READ: begin
								rd_cnt_q <= '0;
								state_q  <= tbd_pkg::ST_READ;
							end
							default: ; // unused codes: no effect
						endcase
					end
				end
				tbd_pkg::ST_STEP: begin
					// the edge check clips the move, the rest of the distance drops
					if (remaining_q == '0 || at_edge) begin
						state_q <= tbd_pkg::ST_IDLE;
					end else begin
						row_pos_q   <= row_nxt;
						col_pos_q   <= col_nxt;
						remaining_q <= remaining_q - 8'd1;
						state_q     <= pen_q ? tbd_pkg::ST_RD : tbd_pkg::ST_STEP;
					end
				end
				tbd_pkg::ST_RD: begin
					state_q <= tbd_pkg::ST_WR;
				end
				tbd_pkg::ST_WR: begin
					row_valid_q[row_pos_q] <= 1'b1;
					state_q                <= tbd_pkg::ST_STEP;
				end
				tbd_pkg::ST_READ: begin
					pend_s1 <= 1'b1;
					if (rd_cnt_q == RD_LAST) begin
						state_q <= tbd_pkg::ST_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q + RD_W'(1);
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		row_vld_q    <= row_valid_q[row_pos_q];
		pend_idx_s1  <= rd_cnt_q;
		pend_last_s1 <= (rd_cnt_q == RD_LAST);
		pend_vld_s1  <= row_valid_q[POS_W'(rd_cnt_q)];
		row_index_q  <= 5'(pend_idx_s1);
		row_bits_q   <= out_bits;
		last_row_q   <= pend_last_s1;
	end

	assign strobe    = strobe_q;
	assign row_index = row_index_q;
	assign row_bits  = row_bits_q;
	assign last_row  = last_row_q;

	// a row word only ever follows an issued read back address
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(pend_s1))
		else $error("row word without read back address");

	// the last flag comes only with the final row
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_row_q) |-> (row_index_q == 5'(OUT_ROWS - 1)))
		else $error("last row flag on wrong row");

	// bitmap is written only while the pen is down
	a_we_pen: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> pen_q)
		else $error("bitmap write with pen up");

	// an unfinished move keeps the block busy
	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbd_pkg::ST_STEP && remaining_q != '0 && !at_edge) |=> busy)
		else $error("move left early");

endmodule

### sim/tbd_checker.sv
// Checker for the turtle bitmap drawer: tracks pose and bitmap, predicts and compares row words.
module tbd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  distance,
	input  logic        strobe,
	input  logic [4:0]  row_index,
	input  logic [31:0] row_bits,
	input  logic        last_row,
	output int          fail_count,
	output int          rows_owed
);

	localparam int unsigned GRID = 32;

	typedef struct packed {
		logic [4:0]  idx;
		logic [31:0] bits;
		logic        last;
	} row_word_t;

	row_word_t          owed_words [$];
	logic [31:0]        canvas [GRID];
	logic [4:0]         pos_row;
	logic [4:0]         pos_col;
	tbd_pkg::heading_t  facing;
	logic               drawing;
	int                 faults;

	initial begin
		for (int r = 0; r < GRID; r++)
			canvas[r] = '0;
		pos_row = '0;
		pos_col = '0;
		facing  = tbd_pkg::HEAD_COL_UP;
		drawing = 1'b0;
		faults  = 0;
	end

	always @(posedge clk) begin : watch
		row_word_t   want;
		int unsigned room;
		int unsigned steps;

		// result side first: a read accepted on this edge cannot show a row yet
		if (strobe === 1'b1) begin
			if (owed_words.size() == 0) begin
				$error("unexpected row word: row_index %0d row_bits %h", row_index, row_bits);
				faults++;
			end else begin
				want = owed_words.pop_front();
				if (row_index !== want.idx) begin
					$error("row_index: expected %0d, actual %0d", want.idx, row_index);
					faults++;
				end
				if (row_bits !== want.bits) begin
					$error("row_bits: expected %h, actual %h", want.bits, row_bits);
					faults++;
				end
				if (last_row !== want.last) begin
					$error("last_row: expected %0d, actual %0d", want.last, last_row);
					faults++;
				end
			end
		end

		if (arst_n && start === 1'b1 && busy === 1'b0) begin
			case (req_type)
				tbd_pkg::REQ_PEN_UP:   drawing = 1'b0;
				tbd_pkg::REQ_PEN_DOWN: drawing = 1'b1;
				tbd_pkg::REQ_RIGHT:    facing = tbd_pkg::heading_t'(facing + 2'd1);
				tbd_pkg::REQ_LEFT:     facing = tbd_pkg::heading_t'(facing - 2'd1);
				tbd_pkg::REQ_MOVE: begin
					case (facing)
						tbd_pkg::HEAD_COL_UP:   room = GRID - 1 - pos_col;
						tbd_pkg::HEAD_ROW_UP:   room = GRID - 1 - pos_row;
						tbd_pkg::HEAD_COL_DOWN: room = pos_col;
						default:                room = pos_row;
					endcase
					steps = (distance > room) ? room : distance;
					// starting cell is never marked, only the cells entered
					for (int k = 0; k < steps; k++) begin
						case (facing)
							tbd_pkg::HEAD_COL_UP:   pos_col = pos_col + 5'd1;
							tbd_pkg::HEAD_ROW_UP:   pos_row = pos_row + 5'd1;
							tbd_pkg::HEAD_COL_DOWN: pos_col = pos_col - 5'd1;
							default:                pos_row = pos_row - 5'd1;
						endcase
						if (drawing)
							canvas[pos_row][pos_col] = 1'b1;
					end
				end
				tbd_pkg::REQ_READ: begin
					for (int r = 0; r < GRID; r++) begin
						want.idx  = r[4:0];
						want.bits = canvas[r];
						want.last = (r == GRID - 1);
						owed_words.push_back(want);
					end
				end
				default: ;
			endcase
		end

		fail_count <= faults;
		rows_owed  <= owed_words.size();
	end

endmodule

### sim/tb_top.sv
// Testbench top for the turtle bitmap drawer: drives command words and gives the verdict.
module tb_top;

	localparam int CLK_PERIOD = 12;
	// codes the block must ignore
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_WORDS = 200;
	// no idling once this many random words have gone in
	localparam int CALM_TAIL_FROM = 170;
	// longer than the longest move with the pen down and than a read back
	localparam int SETTLE_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [7:0]  distance = '0;
	logic        strobe;
	logic [4:0]  row_index;
	logic [31:0] row_bits;
	logic        last_row;
	int          fail_count;
	int          rows_owed;

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	turtle_bitmap_drawer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.distance  (distance),
		.strobe    (strobe),
		.row_index (row_index),
		.row_bits  (row_bits),
		.last_row  (last_row)
	);

	tbd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.distance   (distance),
		.strobe     (strobe),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.last_row   (last_row),
		.fail_count (fail_count),
		.rows_owed  (rows_owed)
	);

	// Present one command word and hold it until an edge sees busy low.
	// Called just after an edge, so busy read here is the value that edge used.
	task automatic send_word(input logic [2:0] code, input logic [7:0] span);
		start    <= 1'b1;
		req_type <= code;
		distance <= span;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Idle gap: start low, fields carry junk the block should not look at.
	task automatic idle_gap(input int cycles);
		start    <= 1'b0;
		req_type <= 3'($urandom);
		distance <= 8'($urandom);
		repeat (cycles)
			@(posedge clk);
	endtask

	// Stop sending until every owed row word has come and the block is idle.
	// One edge first, so the checker's count includes the last accepted word.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (rows_owed != 0 || busy)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int          issued;
		int          roll;
		bit          calm;
		bit          drained;
		logic [2:0]  code;
		logic [7:0]  span;

		issued  = 0;
		calm    = 1'b0;
		drained = 1'b0;

		// single reset at the start of the run
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty read back, heading wrap both ways, zero distance,
		// clipping at every edge but the left one, distance on non-move words, spare codes.
		send_word(tbd_pkg::REQ_READ,     8'd0);
		send_word(tbd_pkg::REQ_LEFT,     8'd0);   // 0 -> 3, wraps downwards
		send_word(tbd_pkg::REQ_RIGHT,    8'd0);   // 3 -> 0, wraps upwards
		send_word(tbd_pkg::REQ_MOVE,     8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd3);   // pen up, nothing marked
		send_word(tbd_pkg::REQ_PEN_DOWN, 8'd255);
		send_word(tbd_pkg::REQ_MOVE,     8'd0);   // pen down but no step, start cell stays clear
		send_word(tbd_pkg::REQ_MOVE,     8'd255); // runs to the right edge
		send_word(tbd_pkg::REQ_RIGHT,    8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd255); // runs to the bottom edge
		send_word(tbd_pkg::REQ_RIGHT,    8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd7);
		send_word(tbd_pkg::REQ_LEFT,     8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd9);   // already on the edge, clipped to nothing
		send_word(tbd_pkg::REQ_RIGHT,    8'd0);
		send_word(tbd_pkg::REQ_RIGHT,    8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd255); // back up to row 0
		send_word(REQ_SPARE_LO,          8'd255);
		send_word(REQ_SPARE_HI,          8'd0);
		send_word(tbd_pkg::REQ_PEN_UP,   8'd255);
		send_word(tbd_pkg::REQ_LEFT,     8'd0);
		send_word(tbd_pkg::REQ_MOVE,     8'd4);
		send_word(tbd_pkg::REQ_READ,     8'd170);

		// Random part: mostly drawing with short moves so the pen stays on the grid,
		// some long moves to hit the edges, regular read backs.
		while (issued < RANDOM_WORDS) begin
			roll = $urandom_range(99);
			span = 8'($urandom);
			if (roll < 36) begin
				code = tbd_pkg::REQ_MOVE;
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5, 6: span = 8'($urandom_range(15));
					7, 8:                span = 8'($urandom_range(40, 16));
					default:             span = 8'($urandom);
				endcase
			end else if (roll < 52)
				code = tbd_pkg::REQ_PEN_DOWN;
			else if (roll < 60)
				code = tbd_pkg::REQ_PEN_UP;
			else if (roll < 72)
				code = tbd_pkg::REQ_RIGHT;
			else if (roll < 84)
				code = tbd_pkg::REQ_LEFT;
			else if (roll < 93)
				code = tbd_pkg::REQ_READ;
			else
				code = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;

			// alternate stretches with and without idling
			if (issued % 25 == 0)
				calm = 1'($urandom_range(1));
			if (issued < CALM_TAIL_FROM && !calm && $urandom_range(3) == 0)
				idle_gap($urandom_range(5, 1));

			// halfway through, let everything owed come out before carrying on
			if (issued == RANDOM_WORDS / 2 && !drained) begin
				drain();
				drained = 1'b1;
			end

			send_word(code, span);
			issued++;
		end

		// wrap up: all row words in, then a settling margin for stray strobes
		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (fail_count == 0 && rows_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin : watchdog
		#(CLK_PERIOD * 400000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
